### src/utf8v_pkg.sv
// Package for the UTF-8 identifier validator: byte class constants,
// the per-text decode state type and the code point minimum lookup.
// No dependencies.
package utf8v_pkg;

	localparam logic [7:0] ByteSpace    = 8'h20;
	localparam logic [7:0] ByteDel      = 8'h7f;
	localparam logic [7:0] ByteAsciiTop = 8'h80;
	localparam logic [7:0] Lead2Lo      = 8'hc2;
	localparam logic [7:0] Lead2Hi      = 8'hdf;
	localparam logic [7:0] Lead3Lo      = 8'he0;
	localparam logic [7:0] Lead3Hi      = 8'hef;
	localparam logic [7:0] Lead4Lo      = 8'hf0;
	localparam logic [7:0] Lead4Hi      = 8'hf4;
	localparam logic [7:0] ContMask     = 8'hc0;
	localparam logic [7:0] ContTag      = 8'h80;
	localparam logic [7:0] ByteEnd      = 8'h00;

	localparam logic [20:0] CodeMax      = 21'h10ffff;
	localparam logic [20:0] SurrogateLo  = 21'h00d800;
	localparam logic [20:0] SurrogateHi  = 21'h00dfff;

	localparam logic [1:0] ClassNone  = 2'd0;
	localparam logic [1:0] ClassTwo   = 2'd1;
	localparam logic [1:0] ClassThree = 2'd2;
	localparam logic [1:0] ClassFour  = 2'd3;

	typedef struct packed {
		logic        fault;
		logic [1:0]  pending;
		logic [20:0] code_point;
		logic [1:0]  min_class;
	} decode_state_t;

	// Smallest code point that a sequence of the given class may encode.
	function automatic logic [20:0] class_minimum(input logic [1:0] cls);
		logic [20:0] m;
		unique case (cls)
			ClassTwo:   m = 21'h000080;
			ClassThree: m = 21'h000800;
			ClassFour:  m = 21'h010000;
			default:    m = 21'h000000;
		endcase
		return m;
	endfunction

endpackage

### src/utf8v_step.sv
// Next-state logic for one non-terminating text byte: length limit,
// lead byte decode, continuation assembly and code point range checks.
// Depends on utf8v_pkg.
module utf8v_step #(
	parameter int COUNT_BITS = 8
) (
	input  utf8v_pkg::decode_state_t cur,
	input  logic [COUNT_BITS-1:0]    count,
	input  logic [7:0]               text_byte,
	input  logic [7:0]               max_bytes,
	output utf8v_pkg::decode_state_t nxt,
	output logic [COUNT_BITS-1:0]    nxt_count
);

	localparam int CmpW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	logic        over;
	logic [20:0] cp_new;
	logic        cp_bad;

	assign over   = CmpW'(count) >= CmpW'(max_bytes);
	assign cp_new = {cur.code_point[14:0], text_byte[5:0]};
	assign cp_bad = (cp_new < utf8v_pkg::class_minimum(cur.min_class)) ||
			(cp_new > utf8v_pkg::CodeMax) ||
			((cp_new >= utf8v_pkg::SurrogateLo) && (cp_new <= utf8v_pkg::SurrogateHi));

	assign nxt_count = (count == {COUNT_BITS{1'b1}}) ? count : count + 1'b1;

	always_comb begin
		nxt = cur;
		// Once a fault is latched, bytes are only counted.
		priority if (cur.fault) begin
			nxt = cur;
		end else if (over) begin
			nxt.fault   = 1'b1;
			nxt.pending = 2'd0;
		end else if (cur.pending != 2'd0) begin
			if ((text_byte & utf8v_pkg::ContMask) != utf8v_pkg::ContTag) begin
				nxt.fault   = 1'b1;
				nxt.pending = 2'd0;
			end else begin
				nxt.code_point = cp_new;
				nxt.pending    = cur.pending - 2'd1;
				if (cur.pending == 2'd1 && cp_bad) begin
					nxt.fault = 1'b1;
				end
			end
		end else if (text_byte < utf8v_pkg::ByteSpace || text_byte == utf8v_pkg::ByteDel) begin
			nxt.fault = 1'b1;
		end else if (text_byte < utf8v_pkg::ByteAsciiTop) begin
			nxt = cur;
		end else if (text_byte >= utf8v_pkg::Lead2Lo && text_byte <= utf8v_pkg::Lead2Hi) begin
			nxt.code_point = {16'd0, text_byte[4:0]};
			nxt.min_class  = utf8v_pkg::ClassTwo;
			nxt.pending    = 2'd1;
		end else if (text_byte >= utf8v_pkg::Lead3Lo && text_byte <= utf8v_pkg::Lead3Hi) begin
			nxt.code_point = {17'd0, text_byte[3:0]};
			nxt.min_class  = utf8v_pkg::ClassThree;
			nxt.pending    = 2'd2;
		end else if (text_byte >= utf8v_pkg::Lead4Lo && text_byte <= utf8v_pkg::Lead4Hi) begin
			nxt.code_point = {18'd0, text_byte[2:0]};
			nxt.min_class  = utf8v_pkg::ClassFour;
			nxt.pending    = 2'd3;
		end else begin
			nxt.fault = 1'b1;
		end
	end

endmodule

### src/utf8_identifier_validator_unit.sv
// A terminating zero byte passes the input register, then the result register.
// Throughput: one byte per cycle, unless verdict_stall holds back a terminator.
// The decode state updates in one pass between the input and result registers.
// Reset clears the decode state, byte count and valid flags; max_bytes returns to 64.
// Top level of the UTF-8 identifier validator; depends on utf8v_pkg and utf8v_step.
module utf8_identifier_validator_unit #(
	parameter int COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       max_bytes_we,
	input  logic [7:0] max_bytes,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic       text_ok,
	output logic [7:0] text_length
);

	localparam int LenW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	logic [7:0]              max_bytes_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	utf8v_pkg::decode_state_t state_q;
	utf8v_pkg::decode_state_t state_nxt;
	logic [COUNT_BITS-1:0]   count_q;
	logic [COUNT_BITS-1:0]   count_nxt;
	logic                    out_valid_q;
	logic                    ok_q;
	logic [7:0]              length_q;
	logic                    slot_free;
	logic                    is_end;
	logic                    advance_s1;
	logic                    take_in;
	logic [LenW-1:0]         count_wide;

	utf8v_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.cur       (state_q),
		.count     (count_q),
		.text_byte (byte_s1),
		.max_bytes (max_bytes_q),
		.nxt       (state_nxt),
		.nxt_count (count_nxt)
	);

	// A data byte never needs the result register; a terminator does.
	assign slot_free  = !out_valid_q || !verdict_stall;
	assign is_end     = byte_s1 == utf8v_pkg::ByteEnd;
	assign advance_s1 = valid_s1 && (!is_end || slot_free);
	assign text_stall = valid_s1 && !advance_s1;
	assign take_in    = text_valid && !text_stall;
	assign count_wide = LenW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= 8'd64;
		end else if (max_bytes_we) begin
			max_bytes_q <= max_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			count_q <= '0;
		end else if (advance_s1) begin
			if (is_end) begin
				state_q <= '0;
				count_q <= '0;
			end else begin
				state_q <= state_nxt;
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && is_end) begin
			out_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && is_end) begin
			ok_q     <= !state_q.fault && state_q.pending == 2'd0 && count_q != '0;
			length_q <= (count_wide > LenW'(255)) ? 8'hff : count_wide[7:0];
		end
	end

	assign verdict_valid = out_valid_q;
	assign text_ok       = ok_q;
	assign text_length   = length_q;

	a_ok_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (!text_ok || text_length != 8'd0))
		else $error("verdict passed an empty text");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && is_end) |=> (state_q == '0 && count_q == '0))
		else $error("terminator did not clear the text state");

	a_fault_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fault |-> state_q.pending == 2'd0)
		else $error("continuation still pending after a fault");

	a_stall_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> (valid_s1 && is_end && out_valid_q))
		else $error("input stalled without a waiting terminator");

endmodule
